/* sv/rars_pkg.sv */
// Shared types for the range-add / range-sum segment tree.
// Holds the command and status structs between the controller and datapath.
// No dependencies.
package rars_pkg;

    localparam int CFG_W   = 11;
    localparam int POS_W   = 11;
    localparam int ADDEND_W = 32;
    localparam int SUM_W   = 64;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic start;      // load request, push root frame
        logic clr;        // clear one memory entry
        logic rd;         // read both memories at the top frame's node
        logic mul_lo;     // low partial product
        logic mul_hi;     // high partial product and final product
        logic mul_pend;   // multiply operand is the read pending addend
        logic oor_ret;    // return value of a node outside the range
        logic cov_fin;    // finish a fully covered node
        logic split;      // push left child
        logic pop;        // drop top frame
        logic parent;     // merge child return into parent
        logic push_right; // push right child
        logic fin_wr;     // recompute an internal node sum on add
        logic out_load;   // load result register
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic oor;
        logic cov;
        logic is_add;
        logic top_empty;
        logic phase;
        logic out_free;
    } status_t;

endpackage

/* sv/rars_dp.sv */
// Datapath: node memories, clearing counter, frame stack, shared multiplier and
// result register. Depends on rars_pkg; driven by rars_ctrl through cmd_t.
module rars_dp #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rars_pkg::cmd_t               cmd,
    output rars_pkg::status_t            status,
    input  logic [rars_pkg::CFG_W-1:0]   element_count,
    input  logic                         req_func,
    input  logic [rars_pkg::POS_W-1:0]   req_low,
    input  logic [rars_pkg::POS_W-1:0]   req_high,
    input  logic [rars_pkg::ADDEND_W-1:0] req_addend,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rars_pkg::SUM_W-1:0]   out_sum
);
    localparam int DEPTH = 4 * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CW    = (PW > rars_pkg::POS_W) ? PW : rars_pkg::POS_W;
    localparam int SD    = $clog2(MAX_ELEMENTS) + 2;
    localparam int SW    = $clog2(SD);
    localparam int SUMW  = rars_pkg::SUM_W;
    localparam int MW    = 32 + PW;

    logic [SUMW-1:0] sum_mem  [DEPTH];
    logic [SUMW-1:0] pend_mem [DEPTH];

    logic [AW-1:0]   st_node  [SD];
    logic [PW-1:0]   st_s     [SD];
    logic [PW-1:0]   st_t     [SD];
    logic [SUMW-1:0] st_carry [SD];
    logic [SUMW-1:0] st_acc   [SD];
    logic            st_phase [SD];

    logic [SW-1:0]   top_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic            func_reg;
    logic [CW-1:0]   low_reg, high_reg;
    logic [SUMW-1:0] addend_reg;
    logic [SUMW-1:0] rd_sum_reg, rd_pend_reg;
    logic [SUMW-1:0] prod_lo_reg, prod_reg, ret_reg;
    logic            out_valid_reg;
    logic [SUMW-1:0] out_sum_reg;

    logic [AW-1:0]   node;
    logic [PW-1:0]   s_pos, t_pos, len, mid, n_eff;
    logic [PW:0]     st_sum;
    logic [CW-1:0]   s_c, t_c;
    logic [SUMW-1:0] mul_op, carry_new, cov_sum, acc_new;
    logic [31:0]     mul_half;
    logic [MW-1:0]   mul_p;
    logic [AW-1:0]   wr_addr;

    assign node   = st_node[top_reg];
    assign s_pos  = st_s[top_reg];
    assign t_pos  = st_t[top_reg];
    assign len    = t_pos - s_pos + PW'(1);
    assign st_sum = {1'b0, s_pos} + {1'b0, t_pos};
    assign mid    = st_sum[PW:1];
    assign s_c    = CW'(s_pos);
    assign t_c    = CW'(t_pos);

    always_comb
    begin
        if (element_count == '0)
            n_eff = PW'(1);
        else if (32'(element_count) > 32'(MAX_ELEMENTS))
            n_eff = PW'(MAX_ELEMENTS);
        else
            n_eff = PW'(element_count);
    end

    assign mul_op    = cmd.mul_pend ? rd_pend_reg
                     : ((func_reg == rars_pkg::FUNC_ADD) ? addend_reg : st_carry[top_reg]);
    assign mul_half  = cmd.mul_hi ? mul_op[63:32] : mul_op[31:0];
    assign mul_p     = MW'(mul_half) * MW'(len);
    assign carry_new = rd_pend_reg + st_carry[top_reg];
    assign cov_sum   = rd_sum_reg + prod_reg;
    assign acc_new   = st_acc[top_reg] + ret_reg;
    assign wr_addr   = cmd.clr ? clr_cnt_reg : node;

    assign status.clr_done  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.oor       = (s_c > high_reg) || (t_c < low_reg);
    assign status.cov       = (s_c >= low_reg) && (t_c <= high_reg);
    assign status.is_add    = (func_reg == rars_pkg::FUNC_ADD);
    assign status.top_empty = (top_reg == '0);
    assign status.phase     = st_phase[top_reg];
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

    // Node memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (cmd.clr || (cmd.cov_fin && func_reg == rars_pkg::FUNC_ADD) || cmd.fin_wr)
        begin
            if (cmd.clr)
                sum_mem[wr_addr] <= '0;
            else if (cmd.fin_wr)
                sum_mem[wr_addr] <= st_acc[top_reg] + prod_reg;
            else
                sum_mem[wr_addr] <= cov_sum;
        end
        if (cmd.clr || (cmd.cov_fin && func_reg == rars_pkg::FUNC_ADD))
        begin
            if (cmd.clr)
                pend_mem[wr_addr] <= '0;
            else
                pend_mem[wr_addr] <= rd_pend_reg + addend_reg;
        end
        if (cmd.rd)
        begin
            rd_sum_reg  <= sum_mem[node];
            rd_pend_reg <= pend_mem[node];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd.start)
                top_reg <= '0;
            else if (cmd.split || cmd.push_right)
                top_reg <= top_reg + SW'(1);
            else if (cmd.pop)
                top_reg <= top_reg - SW'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg        <= req_func;
            low_reg         <= CW'(req_low);
            high_reg        <= CW'(req_high);
            addend_reg      <= {{32{req_addend[31]}}, req_addend};
            st_node[0]      <= AW'(1);
            st_s[0]         <= PW'(1);
            st_t[0]         <= n_eff;
            st_carry[0]     <= '0;
            st_acc[0]       <= '0;
            st_phase[0]     <= 1'b0;
        end
        if (cmd.mul_lo)
            prod_lo_reg <= 64'(mul_p);
        if (cmd.mul_hi)
            prod_reg <= prod_lo_reg + {mul_p[31:0], 32'b0};
        if (cmd.oor_ret)
            ret_reg <= (func_reg == rars_pkg::FUNC_ADD) ? rd_sum_reg : '0;
        if (cmd.cov_fin)
            ret_reg <= cov_sum;
        if (cmd.fin_wr)
            ret_reg <= st_acc[top_reg] + prod_reg;
        if (cmd.parent)
        begin
            st_acc[top_reg]   <= acc_new;
            st_phase[top_reg] <= 1'b1;
            ret_reg           <= acc_new;
        end
        if (cmd.split)
        begin
            st_carry[top_reg]          <= carry_new;
            st_node[top_reg + SW'(1)]  <= {node[AW-2:0], 1'b0};
            st_s[top_reg + SW'(1)]     <= s_pos;
            st_t[top_reg + SW'(1)]     <= mid;
            st_carry[top_reg + SW'(1)] <= carry_new;
            st_acc[top_reg + SW'(1)]   <= '0;
            st_phase[top_reg + SW'(1)] <= 1'b0;
        end
        if (cmd.push_right)
        begin
            st_node[top_reg + SW'(1)]  <= {node[AW-2:0], 1'b1};
            st_s[top_reg + SW'(1)]     <= mid + PW'(1);
            st_t[top_reg + SW'(1)]     <= t_pos;
            st_carry[top_reg + SW'(1)] <= st_carry[top_reg];
            st_acc[top_reg + SW'(1)]   <= '0;
            st_phase[top_reg + SW'(1)] <= 1'b0;
        end
        if (cmd.out_load)
            out_sum_reg <= ret_reg;
    end

`ifndef SYNTH
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.split || cmd.push_right) |-> (top_reg != SW'(SD - 1)))
        else $error("frame stack overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (top_reg != '0))
        else $error("pop from the root frame");
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");
`endif
endmodule

/* sv/rars_ctrl.sv */
// Controller: sequences the clearing pass and the depth-first tree walk.
// Depends on rars_pkg; drives rars_dp through cmd_t and reads status_t.
module rars_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rars_pkg::status_t   status,
    output rars_pkg::cmd_t      cmd
);
    typedef enum logic [15:0] {
        CLEAR  = 16'b0000000000000001,
        IDLE   = 16'b0000000000000010,
        EVAL   = 16'b0000000000000100,
        DECIDE = 16'b0000000000001000,
        CMUL2  = 16'b0000000000010000,
        CFIN   = 16'b0000000000100000,
        POP    = 16'b0000000001000000,
        PARENT = 16'b0000000010000000,
        PUSHR  = 16'b0000000100000000,
        FRD    = 16'b0000001000000000,
        FMUL1  = 16'b0000010000000000,
        FMUL2  = 16'b0000100000000000,
        FWR    = 16'b0001000000000000,
        DONE   = 16'b0010000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            CLEAR:
            begin
                cmd.clr = 1'b1;
                if (status.clr_done)
                    state_next = IDLE;
            end
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = EVAL;
                end
            end
            EVAL:
            begin
                cmd.rd     = 1'b1;
                state_next = DECIDE;
            end
            DECIDE:
            begin
                if (status.oor)
                begin
                    cmd.oor_ret = 1'b1;
                    state_next  = POP;
                end
                else if (status.cov)
                begin
                    cmd.mul_lo = 1'b1;
                    state_next = CMUL2;
                end
                else
                begin
                    cmd.split  = 1'b1;
                    state_next = EVAL;
                end
            end
            CMUL2:
            begin
                cmd.mul_hi = 1'b1;
                state_next = CFIN;
            end
            CFIN:
            begin
                cmd.cov_fin = 1'b1;
                state_next  = POP;
            end
            POP:
            begin
                if (status.top_empty)
                    state_next = DONE;
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = PARENT;
                end
            end
            PARENT:
            begin
                cmd.parent = 1'b1;
                if (!status.phase)
                    state_next = PUSHR;
                else if (status.is_add)
                    state_next = FRD;
                else
                    state_next = POP;
            end
            PUSHR:
            begin
                cmd.push_right = 1'b1;
                state_next     = EVAL;
            end
            FRD:
            begin
                cmd.rd     = 1'b1;
                state_next = FMUL1;
            end
            FMUL1:
            begin
                cmd.mul_lo   = 1'b1;
                cmd.mul_pend = 1'b1;
                state_next   = FMUL2;
            end
            FMUL2:
            begin
                cmd.mul_hi   = 1'b1;
                cmd.mul_pend = 1'b1;
                state_next   = FWR;
            end
            FWR:
            begin
                cmd.fin_wr = 1'b1;
                state_next = POP;
            end
            DONE:
            begin
                if (status.is_add)
                    state_next = IDLE;
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
                state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CLEAR;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != CLEAR) |=> (state_reg != CLEAR))
        else $error("clearing pass re-entered");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == EVAL))
        else $error("request start did not begin a walk");
    a_one_mul_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_lo && cmd.mul_hi))
        else $error("both multiplier steps in one cycle");
`endif
endmodule

/* sv/range_add_range_sum_tree.sv */
// Top level of the range-add / range-sum segment tree.
// Depends on rars_pkg, rars_ctrl and rars_dp.
//
// Requests enter on the s_axis channel: tuser selects add (0) or query (1),
// tdata carries the range and the addend. A query gives one result on the
// m_axis channel (the 64-bit range sum, modulo 2^64); an add gives none.
// cfg_wr_en/cfg_wr_data set element_count; the user must write it only while
// the block is idle, the block does not enforce this. Requests are handled
// one at a time. The walk visits each node of the depth-first traversal
// through a single node memory port: an out-of-range node is read, decided
// and popped; a covered node is read, decided, multiplied, finished and popped;
// a split node is read and decided, then when its left child pops it merges
// and pushes its right child, and merges again after that one (on add also
// recomputing its sum). IDLE accepts the request, DONE hands over the result.
// For 1024 positions a walk visits up to about 40 nodes. After reset a clearing
// pass zeroes all 4*MAX_ELEMENTS node memory entries; s_axis_tready stays low until it ends.
// The result sits in an output register; the next request is accepted
// while it waits, and a later query result waits until it is taken.
module range_add_range_sum_tree #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // range_low[10:0], range_high[21:11], addend[53:22], zero
    input  logic [0:0]  s_axis_tuser,  // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // range_sum[63:0]
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data
);
    rars_pkg::cmd_t    cmd;
    rars_pkg::status_t status;
    logic [rars_pkg::CFG_W-1:0] element_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            element_count_reg <= 11'd1024;
        else if (cfg_wr_en)
            element_count_reg <= cfg_wr_data;
    end

    rars_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rars_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .element_count (element_count_reg),
        .req_func      (s_axis_tuser[0]),
        .req_low       (s_axis_tdata[10:0]),
        .req_high      (s_axis_tdata[21:11]),
        .req_addend    (s_axis_tdata[53:22]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_sum       (m_axis_tdata)
    );
endmodule
